// ----- hw/rtl/mma_pkg.sv -----
// Package for the multichannel moving average: sizes, widths and the
// command and status structs between controller and datapath.
// Depends on nothing; every other file but mma_ram refers to it.
package mma_pkg;

  // Window length and number of channels.
  localparam int WINDOW   = 128;
  localparam int CHANNELS = 32;

  // Field widths of the transactions.
  localparam int CHAN_W   = 5;
  localparam int SAMPLE_W = 16;

  // Derived widths of the per-channel state.
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SUM_W      = SAMPLE_W + PTR_W;
  localparam int HIST_DEPTH = CHANNELS * WINDOW;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int STEP_W     = $clog2(SUM_W + 1);

  // Function codes of an input transaction.
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // an input transaction is taken this cycle
    logic read;      // read the oldest history slot
    logic update;    // fold in the sample, write history, start the divide
    logic div_step;  // one restoring divide step
    logic out_load;  // move the quotient into the output register
  } mma_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic add_item;  // the offered transaction is an add to a valid channel
    logic out_free;  // the output register can take a new result
  } mma_status_t;

endpackage

// ----- hw/rtl/mma_in_if.sv -----
// Input channel of the moving average: valid/ready with func, channel, sample.
// Depends on mma_pkg for the field widths.
interface mma_in_if;
  logic                                valid;
  logic                                ready;
  logic                                func;
  logic [mma_pkg::CHAN_W-1:0]          channel;
  logic signed [mma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, func, channel, sample, input ready);
  modport sink (input valid, func, channel, sample, output ready);
endinterface

// ----- hw/rtl/mma_out_if.sv -----
// Output channel of the moving average: valid/ready with channel and mean.
// Depends on mma_pkg for the field widths.
interface mma_out_if;
  logic                                valid;
  logic                                ready;
  logic [mma_pkg::CHAN_W-1:0]          out_channel;
  logic signed [mma_pkg::SAMPLE_W-1:0] average;

  modport source (output valid, out_channel, average, input ready);
  modport sink (input valid, out_channel, average, output ready);
endinterface

// ----- hw/rtl/mma_ram.sv -----
// Generic single-port RAM with registered read data.
// Depends on nothing.
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle: write, or read into the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- hw/rtl/mma_ctrl.sv -----
// Controller of the moving average: sequences read, update, divide and output.
// Depends on mma_pkg for the command and status structs.
module mma_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mma_pkg::mma_status_t st,
  output mma_pkg::mma_cmd_t    cmd
);
  import mma_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_DIVIDE,
    S_DONE
  } state_t;

  state_t              state;
  logic [STEP_W-1:0]   step;

  // Commands decode from the current state, gated by in_valid and out_free.
  always_comb begin
    cmd          = '0;
    in_ready     = (state == S_IDLE);
    cmd.accept   = (state == S_IDLE) && in_valid;
    cmd.read     = (state == S_READ);
    cmd.update   = (state == S_UPDATE);
    cmd.div_step = (state == S_DIVIDE);
    cmd.out_load = (state == S_DONE) && st.out_free;
  end

  // State register and divide step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && st.add_item) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          step  <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          step <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (st.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/mma_datapath.sv -----
// Datapath of the moving average: per-channel sums, counts and pointers,
// the history RAM, a restoring divider and the output register.
// Depends on mma_pkg and mma_ram.
module mma_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_func,
  input  logic [mma_pkg::CHAN_W-1:0]          in_channel,
  input  logic signed [mma_pkg::SAMPLE_W-1:0] in_sample,
  input  mma_pkg::mma_cmd_t                   cmd,
  output mma_pkg::mma_status_t                st,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mma_pkg::CHAN_W-1:0]          out_channel,
  output logic signed [mma_pkg::SAMPLE_W-1:0] average
);
  import mma_pkg::*;

  // Per-channel state.
  logic signed [SUM_W-1:0] sum_arr [CHANNELS];
  logic [CNT_W-1:0]        cnt_arr [CHANNELS];
  logic [PTR_W-1:0]        ptr_arr [CHANNELS];

  // Latched transaction.
  logic [CH_IDX_W-1:0]        ch;
  logic [CHAN_W-1:0]          chan;
  logic signed [SAMPLE_W-1:0] smp;

  // Divider registers.
  logic [SUM_W-1:0] quo;
  logic [CNT_W-1:0] rem;
  logic [CNT_W-1:0] dvs;
  logic             neg;

  logic                    chan_ok;
  logic [CH_IDX_W-1:0]     in_idx;
  logic [PTR_W-1:0]        ptr;
  logic [CNT_W-1:0]        cnt;
  logic                    full;
  logic [HIST_AW-1:0]      slot;
  logic [SAMPLE_W-1:0]     hist_rdata;
  logic signed [SUM_W-1:0] oldest;
  logic signed [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0]        cnt_next;
  logic [PTR_W-1:0]        ptr_next;
  logic [CNT_W:0]          trial;
  logic                    trial_ge;
  logic [SUM_W-1:0]        q_signed;

  // Channel check and status.
  assign chan_ok     = (32'(in_channel) < CHANNELS);
  assign in_idx      = CH_IDX_W'(in_channel);
  assign st.add_item = (in_func == FUNC_ADD) && chan_ok;
  assign st.out_free = !out_valid || out_ready;

  // Current channel state and the slot being replaced.
  assign ptr  = ptr_arr[ch];
  assign cnt  = cnt_arr[ch];
  assign full = (cnt == CNT_W'(WINDOW));
  assign slot = HIST_AW'(HIST_AW'(ch) * HIST_AW'(WINDOW)) + HIST_AW'(ptr);

  // Window update: the oldest sample counts only once the window is full.
  assign oldest   = full ? SUM_W'(signed'(hist_rdata)) : '0;
  assign sum_next = sum_arr[ch] - oldest + SUM_W'(smp);
  assign cnt_next = full ? cnt : cnt + 1'b1;
  assign ptr_next = (ptr == PTR_W'(WINDOW - 1)) ? '0 : ptr + 1'b1;

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .en    (cmd.read || cmd.update),
    .we    (cmd.update),
    .addr  (slot),
    .wdata (smp),
    .rdata (hist_rdata)
  );

  // Latch the transaction when it is accepted.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ch   <= in_idx;
      chan <= in_channel;
      smp  <= in_sample;
    end
  end

  // Per-channel sum, count and pointer: cleared by reset or a clear item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_arr[i] <= '0;
        cnt_arr[i] <= '0;
        ptr_arr[i] <= '0;
      end
    end else if (cmd.accept && in_func == FUNC_CLEAR && chan_ok) begin
      sum_arr[in_idx] <= '0;
      cnt_arr[in_idx] <= '0;
      ptr_arr[in_idx] <= '0;
    end else if (cmd.update) begin
      sum_arr[ch] <= sum_next;
      cnt_arr[ch] <= cnt_next;
      ptr_arr[ch] <= ptr_next;
    end
  end

  // One restoring step: shift in the next dividend bit and try to subtract.
  assign trial    = {rem, quo[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, dvs});

  // Divider: magnitude of the sum over the fill count, one bit a cycle.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      neg <= sum_next[SUM_W-1];
      quo <= sum_next[SUM_W-1] ? SUM_W'(-sum_next) : SUM_W'(sum_next);
      rem <= '0;
      dvs <= cnt_next;
    end else if (cmd.div_step) begin
      rem <= trial_ge ? CNT_W'(trial - {1'b0, dvs}) : CNT_W'(trial);
      quo <= {quo[SUM_W-2:0], trial_ge};
    end
  end

  // Restore the sign; the mean always fits in a sample.
  assign q_signed = neg ? SUM_W'(-quo) : quo;

  // Output register holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_channel <= chan;
      average     <= signed'(q_signed[SAMPLE_W-1:0]);
    end
  end

endmodule

// ----- hw/rtl/multichannel_moving_average.sv -----
// Top level of the multichannel moving average.
// Depends on mma_pkg, mma_in_if, mma_out_if, mma_ctrl and mma_datapath.
//
// Usage:
// The samples channel takes transactions with func, channel and sample.
// An add (func 0) folds a signed Q8.8 sample into that channel's window
// of the last 128 samples and gives one transaction on the averages
// channel: the channel and the window mean, truncated toward zero.
// A clear (func 1) empties the channel's window and gives no result.
// After acceptance, an add reads the oldest history slot from the RAM,
// updates sum, count and pointer, runs a restoring divider by the fill
// count, one quotient bit a cycle, and loads the output register,
// where the result shows valid. Items are taken one at a time, so an
// add occupies the block up to the next acceptance; a clear leaves it
// free for the next item.
// The result waits in an output register; while it waits, the next
// item is accepted and processed, and only its own result stalls until
// the receiver takes the previous one.
// Reset clears every channel's sum, count and pointer at once; the
// history RAM needs no clearing; a slot is used only once written.
module multichannel_moving_average (
  input logic       clk,
  input logic       rst,
  mma_in_if.sink    samples,
  mma_out_if.source averages
);
  import mma_pkg::*;

  mma_cmd_t    cmd;
  mma_status_t st;

  mma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .st       (st),
    .cmd      (cmd)
  );

  mma_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_func     (samples.func),
    .in_channel  (samples.channel),
    .in_sample   (samples.sample),
    .cmd         (cmd),
    .st          (st),
    .out_valid   (averages.valid),
    .out_ready   (averages.ready),
    .out_channel (averages.out_channel),
    .average     (averages.average)
  );

endmodule
